[hdl/buddy_page_allocator_macros.svh]
// Assertion macros for the buddy page allocator controller.
`ifndef BUDDY_PAGE_ALLOCATOR_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BPA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpa assertion failed");

// Next-cycle implication, checked outside reset.
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpa assertion failed");

`endif

[hdl/bpa_pkg.sv]
// Types and codes shared by the buddy page allocator modules.
package bpa_pkg;

    localparam int ORD_W  = 4;
    localparam int PAGE_W = 12;
    localparam int ST_W   = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_ORDER = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [ST_W-1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic              command;
        logic [ORD_W-1:0]  block_order;
        logic [PAGE_W-1:0] page_index;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PAGE_W-1:0] block_page;
        logic [ORD_W-1:0]  result_order;
    } t_out_word;

    typedef struct packed {
        logic             taken;
        logic             known;
        logic [ORD_W-1:0] order;
    } t_meta;

    typedef enum logic [2:0] {
        MEM_NONE, MEM_CLR, MEM_APP0, MEM_APP1, MEM_UNL1, MEM_UNL2, MEM_KILL_P
    } t_mem_op;

    typedef enum logic [2:0] {K_HOLD, K_MAX, K_INC, K_DEC, K_IN, K_META} t_k_op;
    typedef enum logic [2:0] {W_HOLD, W_INC, W_P, W_IN, W_HEAD, W_SPLIT, W_MERGE} t_w_op;
    typedef enum logic [2:0] {P_HOLD, P_ZERO, P_STEP, P_W, P_MERGE} t_p_op;
    typedef enum logic [1:0] {RES_ERR, RES_ALLOC, RES_FREE} t_res_src;

    typedef struct packed {
        t_mem_op         mem_op;
        logic            unl_free;
        t_k_op           k_op;
        t_w_op           w_op;
        t_p_op           p_op;
        logic            ld_top;
        logic            ld_ord;
        logic            res_ld;
        t_res_src        res_src;
        logic [ST_W-1:0] res_st;
    } t_dp_cmd;

    typedef struct packed {
        logic bad_order;
        logic bad_page;
        logic head_nil;
        logic k_is_max;
        logic k_eq_ord;
        logic init_fit;
        logic p_end;
        logic w_last;
        logic split_ok;
        logic merge_ok;
        logic meta_own;
        logic buddy_free;
    } t_dp_st;

endpackage

[hdl/bpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/bpa_datapath.sv]
// Datapath: page tables in RAM, list ends, working registers and result word.
module bpa_datapath #(
    parameter int NUM_PAGES = 4096,
    parameter int TOP_ORDER = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bpa_pkg::t_dp_cmd    i_cmd,
    input  bpa_pkg::t_in_word   i_in_word,
    output bpa_pkg::t_dp_st     o_st,
    output bpa_pkg::t_out_word  o_out_word
);
    import bpa_pkg::*;

    localparam int AW  = $clog2(NUM_PAGES);
    localparam int LW  = $clog2(NUM_PAGES + 1);
    localparam int KW  = $clog2(TOP_ORDER + 1);
    localparam int SW0 = (LW + 1 > TOP_ORDER + 2) ? LW + 1 : TOP_ORDER + 2;
    localparam int SW  = (SW0 > PAGE_W + 1) ? SW0 : PAGE_W + 1;
    localparam int MW  = $bits(t_meta);
    localparam logic [LW-1:0] NIL   = LW'(NUM_PAGES);
    localparam logic [SW-1:0] NIL_S = SW'(NUM_PAGES);

    logic [AW-1:0]    r_w;
    logic [LW-1:0]    r_p;
    logic [AW-1:0]    r_t;
    logic [ORD_W-1:0] r_k;
    logic [ORD_W-1:0] r_ord;
    logic [LW-1:0]    r_tl;
    logic [LW-1:0]    r_head [TOP_ORDER+1];
    logic [LW-1:0]    r_tail [TOP_ORDER+1];
    t_out_word        r_out;

    logic          next_we, prev_we, meta_we;
    logic [AW-1:0] next_wa, prev_wa, meta_wa;
    logic [LW-1:0] next_wd, prev_wd, next_q, prev_q;
    t_meta         meta_wd;
    logic [MW-1:0] meta_q;
    t_meta         meta_rd;

    logic [SW-1:0] p_s, t_s, one_k, one_km1, split_b, merge_b;
    logic [LW-1:0] head_k, tail_k;

    assign p_s     = SW'(r_p);
    assign t_s     = SW'(r_t);
    assign one_k   = SW'(1) << r_k;
    assign one_km1 = SW'(1) << (r_k - ORD_W'(1));
    assign split_b = t_s ^ one_km1;
    assign merge_b = p_s ^ one_k;
    assign head_k  = r_head[r_k[KW-1:0]];
    assign tail_k  = r_tail[r_k[KW-1:0]];
    assign meta_rd = t_meta'(meta_q);

    always_comb begin
        o_st.bad_order  = i_in_word.block_order > ORD_W'(TOP_ORDER);
        o_st.bad_page   = SW'(i_in_word.page_index) >= NIL_S;
        o_st.head_nil   = head_k == NIL;
        o_st.k_is_max   = r_k == ORD_W'(TOP_ORDER);
        o_st.k_eq_ord   = r_k == r_ord;
        o_st.init_fit   = (r_k == '0) ||
                          (((p_s & (one_k - SW'(1))) == '0) && ((p_s + one_k) <= NIL_S));
        o_st.p_end      = p_s >= NIL_S;
        o_st.w_last     = r_w == AW'(NUM_PAGES - 1);
        o_st.split_ok   = split_b < NIL_S;
        o_st.merge_ok   = (r_k != ORD_W'(TOP_ORDER)) && (merge_b < NIL_S);
        o_st.meta_own   = meta_rd.taken && meta_rd.known;
        o_st.buddy_free = !meta_rd.taken && meta_rd.known && (meta_rd.order == r_k);
    end

    // RAM write ports; all reads follow r_w
    always_comb begin
        next_we = 1'b0;
        prev_we = 1'b0;
        meta_we = 1'b0;
        next_wa = r_w;
        prev_wa = r_w;
        meta_wa = r_w;
        next_wd = NIL;
        prev_wd = NIL;
        meta_wd = '0;
        unique case (i_cmd.mem_op)
            MEM_NONE: begin
            end
            MEM_CLR: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                meta_we = 1'b1;
            end
            MEM_APP0: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                prev_wd = tail_k;
                meta_we = 1'b1;
                meta_wd = '{taken: 1'b0, known: 1'b1, order: r_k};
            end
            MEM_APP1: begin
                next_we = r_tl != NIL;
                next_wa = r_tl[AW-1:0];
                next_wd = LW'(r_w);
            end
            MEM_UNL1: begin
                next_we = prev_q != NIL;
                next_wa = prev_q[AW-1:0];
                next_wd = next_q;
                prev_we = next_q != NIL;
                prev_wa = next_q[AW-1:0];
                prev_wd = prev_q;
            end
            MEM_UNL2: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                meta_we = 1'b1;
                meta_wd = i_cmd.unl_free ? '{taken: 1'b1, known: 1'b0, order: '0}
                                         : '{taken: 1'b1, known: 1'b1, order: r_ord};
            end
            MEM_KILL_P: begin
                meta_we = 1'b1;
                meta_wa = r_p[AW-1:0];
                meta_wd = '{taken: 1'b1, known: 1'b0, order: '0};
            end
            default: begin
            end
        endcase
    end

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(r_w), .o_rdata(next_q)
    );

    bpa_ram #(.WIDTH(LW), .DEPTH(NUM_PAGES)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(r_w), .o_rdata(prev_q)
    );

    bpa_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_meta_ram (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_wa), .i_wdata(MW'(meta_wd)),
        .i_raddr(r_w), .o_rdata(meta_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= '0;
            for (int i = 0; i <= TOP_ORDER; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            unique case (i_cmd.w_op)
                W_HOLD:  r_w <= r_w;
                W_INC:   r_w <= r_w + AW'(1);
                W_P:     r_w <= r_p[AW-1:0];
                W_IN:    r_w <= AW'(i_in_word.page_index);
                W_HEAD:  r_w <= head_k[AW-1:0];
                W_SPLIT: r_w <= split_b[AW-1:0];
                W_MERGE: r_w <= merge_b[AW-1:0];
                default: r_w <= r_w;
            endcase
            if (i_cmd.mem_op == MEM_APP0) begin
                if (tail_k == NIL) begin
                    r_head[r_k[KW-1:0]] <= LW'(r_w);
                end
                r_tail[r_k[KW-1:0]] <= LW'(r_w);
            end else if (i_cmd.mem_op == MEM_UNL1) begin
                if (prev_q == NIL) begin
                    r_head[r_k[KW-1:0]] <= next_q;
                end
                if (next_q == NIL) begin
                    r_tail[r_k[KW-1:0]] <= prev_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.k_op)
            K_HOLD:  r_k <= r_k;
            K_MAX:   r_k <= ORD_W'(TOP_ORDER);
            K_INC:   r_k <= r_k + ORD_W'(1);
            K_DEC:   r_k <= r_k - ORD_W'(1);
            K_IN:    r_k <= i_in_word.block_order;
            K_META:  r_k <= meta_rd.order;
            default: r_k <= r_k;
        endcase
        unique case (i_cmd.p_op)
            P_HOLD:  r_p <= r_p;
            P_ZERO:  r_p <= '0;
            P_STEP:  r_p <= LW'(p_s + one_k);
            P_W:     r_p <= LW'(r_w);
            P_MERGE: r_p <= LW'(p_s & ~one_k);
            default: r_p <= r_p;
        endcase
        if (i_cmd.ld_top) begin
            r_t <= head_k[AW-1:0];
        end
        if (i_cmd.ld_ord) begin
            r_ord <= i_in_word.block_order;
        end
        if (i_cmd.mem_op == MEM_APP0) begin
            r_tl <= tail_k;
        end
        if (i_cmd.res_ld) begin
            unique case (i_cmd.res_src)
                RES_ERR:   r_out <= '{status: i_cmd.res_st, block_page: '0, result_order: '0};
                RES_ALLOC: r_out <= '{status: i_cmd.res_st, block_page: t_s[PAGE_W-1:0],
                                      result_order: r_ord};
                RES_FREE:  r_out <= '{status: i_cmd.res_st, block_page: p_s[PAGE_W-1:0],
                                      result_order: r_k};
                default:   r_out <= r_out;
            endcase
        end
    end

    assign o_out_word = r_out;
endmodule

[hdl/bpa_ctrl.sv]
// Controller: sequences reset build, allocate split and free merge steps.
`include "buddy_page_allocator_macros.svh"
module bpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_is_free,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  bpa_pkg::t_dp_st  i_st,
    output bpa_pkg::t_dp_cmd o_cmd
);
    import bpa_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_INIT_K, S_INIT_NEXT, S_IDLE, S_SRCH, S_SPLIT, S_FRD, S_FCHK,
        S_MERGE, S_MRD, S_MCHK, S_MERGE2, S_U0, S_U1, S_U2, S_APP0, S_APP1, S_RES
    } t_state;

    t_state          r_state, n_state, r_ret, n_ret;
    logic            r_valid, n_valid;
    logic [ST_W-1:0] r_res_st, n_res_st;
    t_res_src        r_res_src, n_res_src;
    logic            r_unl_free, n_unl_free;
    logic            out_free;
    t_dp_cmd         cmd;

    assign out_free = !r_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_valid    = r_valid && !i_out_ready;
        n_res_st   = r_res_st;
        n_res_src  = r_res_src;
        n_unl_free = r_unl_free;
        cmd.mem_op   = MEM_NONE;
        cmd.unl_free = r_unl_free;
        cmd.k_op     = K_HOLD;
        cmd.w_op     = W_HOLD;
        cmd.p_op     = P_HOLD;
        cmd.ld_top   = 1'b0;
        cmd.ld_ord   = 1'b0;
        cmd.res_ld   = 1'b0;
        cmd.res_src  = r_res_src;
        cmd.res_st   = r_res_st;
        unique case (r_state)
            S_CLR: begin
                cmd.mem_op = MEM_CLR;
                cmd.w_op   = W_INC;
                if (i_st.w_last) begin
                    cmd.p_op = P_ZERO;
                    cmd.k_op = K_MAX;
                    n_state  = S_INIT_K;
                end
            end
            S_INIT_K: begin
                if (i_st.p_end) begin
                    n_state = S_IDLE;
                end else if (i_st.init_fit) begin
                    cmd.w_op = W_P;
                    n_ret    = S_INIT_NEXT;
                    n_state  = S_APP0;
                end else begin
                    cmd.k_op = K_DEC;
                end
            end
            S_INIT_NEXT: begin
                cmd.p_op = P_STEP;
                cmd.k_op = K_MAX;
                n_state  = S_INIT_K;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_is_free == CMD_ALLOC) begin
                        if (i_st.bad_order) begin
                            n_res_st  = ST_BAD_ORDER;
                            n_res_src = RES_ERR;
                            n_state   = S_RES;
                        end else begin
                            cmd.k_op   = K_IN;
                            cmd.ld_ord = 1'b1;
                            n_unl_free = 1'b0;
                            n_state    = S_SRCH;
                        end
                    end else if (i_st.bad_page) begin
                        n_res_st  = ST_IGNORED;
                        n_res_src = RES_ERR;
                        n_state   = S_RES;
                    end else begin
                        cmd.w_op   = W_IN;
                        n_unl_free = 1'b1;
                        n_state    = S_FRD;
                    end
                end
            end
            S_SRCH: begin
                if (!i_st.head_nil) begin
                    cmd.ld_top = 1'b1;
                    cmd.w_op   = W_HEAD;
                    n_ret      = S_SPLIT;
                    n_state    = S_U0;
                end else if (i_st.k_is_max) begin
                    n_res_st  = ST_NO_MEMORY;
                    n_res_src = RES_ERR;
                    n_state   = S_RES;
                end else begin
                    cmd.k_op = K_INC;
                end
            end
            S_SPLIT: begin
                if (i_st.k_eq_ord) begin
                    n_res_st  = ST_OK;
                    n_res_src = RES_ALLOC;
                    n_state   = S_RES;
                end else begin
                    // upper half of the block goes to the next order down
                    cmd.k_op = K_DEC;
                    cmd.w_op = W_SPLIT;
                    if (i_st.split_ok) begin
                        n_ret   = S_SPLIT;
                        n_state = S_APP0;
                    end
                end
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (i_st.meta_own) begin
                    cmd.k_op = K_META;
                    cmd.p_op = P_W;
                    n_state  = S_MERGE;
                end else begin
                    n_res_st  = ST_IGNORED;
                    n_res_src = RES_ERR;
                    n_state   = S_RES;
                end
            end
            S_MERGE: begin
                if (i_st.merge_ok) begin
                    cmd.w_op = W_MERGE;
                    n_state  = S_MRD;
                end else begin
                    cmd.w_op  = W_P;
                    n_res_st  = ST_OK;
                    n_res_src = RES_FREE;
                    n_ret     = S_RES;
                    n_state   = S_APP0;
                end
            end
            S_MRD: n_state = S_MCHK;
            S_MCHK: begin
                if (i_st.buddy_free) begin
                    n_ret   = S_MERGE2;
                    n_state = S_U0;
                end else begin
                    cmd.w_op  = W_P;
                    n_res_st  = ST_OK;
                    n_res_src = RES_FREE;
                    n_ret     = S_RES;
                    n_state   = S_APP0;
                end
            end
            S_MERGE2: begin
                cmd.mem_op = MEM_KILL_P;
                cmd.p_op   = P_MERGE;
                cmd.k_op   = K_INC;
                n_state    = S_MERGE;
            end
            S_U0: n_state = S_U1;
            S_U1: begin
                cmd.mem_op = MEM_UNL1;
                n_state    = S_U2;
            end
            S_U2: begin
                cmd.mem_op = MEM_UNL2;
                n_state    = r_ret;
            end
            S_APP0: begin
                cmd.mem_op = MEM_APP0;
                n_state    = S_APP1;
            end
            S_APP1: begin
                cmd.mem_op = MEM_APP1;
                n_state    = r_ret;
            end
            S_RES: begin
                if (out_free) begin
                    cmd.res_ld = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ret      <= S_IDLE;
            r_valid    <= 1'b0;
            r_res_st   <= ST_OK;
            r_res_src  <= RES_ERR;
            r_unl_free <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_valid    <= n_valid;
            r_res_st   <= n_res_st;
            r_res_src  <= n_res_src;
            r_unl_free <= n_unl_free;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_valid;
    assign o_cmd       = cmd;

    `BPA_ASSERT_NEXT(a_res_loads_word, (r_state == S_RES) && out_free, r_valid)
    `BPA_ASSERT_NEXT(a_res_to_idle, (r_state == S_RES) && out_free, r_state == S_IDLE)
    `BPA_ASSERT_NEXT(a_accept_leaves_idle, (r_state == S_IDLE) && i_in_valid,
                     r_state != S_IDLE)
    `BPA_ASSERT_IMP(a_ret_target, (r_state == S_U2) || (r_state == S_APP1),
                    (r_ret == S_SPLIT) || (r_ret == S_MERGE2) || (r_ret == S_RES) ||
                    (r_ret == S_INIT_NEXT))
endmodule

[hdl/buddy_page_allocator.sv]
// Top level of the buddy page allocator: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready / i_in_word): one word per request,
// an allocate of 2^block_order pages or a free of the block at page_index.
// Output channel (o_out_valid / i_out_ready / o_out_word): exactly one word
// per request with status, block page and order.
// One request is worked on at a time. Allocate: search the orders upward, unlink
// the found block, append the upper half at each split level, load the result.
// Free: check the page, unlink each free buddy while merging, append, load the result.
// The per-page tables sit in RAMs with one write port each, so an unlink
// reads the links of a page before it writes them in separate steps.
// After reset the block sweeps all NUM_PAGES entries of the page tables,
// then builds the initial free lists, each block at the largest order that
// fits; o_in_ready stays low until done.
// A finished word waits in the output register while the next request is
// taken; if the receiver still stalls when that request ends, the block
// holds in its result state until the register frees.
module buddy_page_allocator #(
    parameter int NUM_PAGES = 4096,
    parameter int TOP_ORDER = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpa_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bpa_pkg::t_out_word o_out_word
);
    import bpa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_st  dp_st;

    bpa_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_is_free(i_in_word.command),
        .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_st(dp_st),
        .o_cmd(dp_cmd)
    );

    bpa_datapath #(.NUM_PAGES(NUM_PAGES), .TOP_ORDER(TOP_ORDER)) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(dp_cmd),
        .i_in_word(i_in_word),
        .o_st(dp_st),
        .o_out_word(o_out_word)
    );
endmodule

[verif/tb.sv]
// Testbench for the buddy page allocator: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module tb;
    import bpa_pkg::*;

    localparam int NPAGES   = 4096;
    localparam int TOP_ORD  = 10;
    localparam int NIL      = NPAGES;
    localparam int WDOG_MAX = 20000;
    localparam int N_RANDOM = 1000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    buddy_page_allocator #(.NUM_PAGES(NPAGES), .TOP_ORDER(TOP_ORD)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // shadow of the allocator state
    bit        pg_taken [NPAGES];
    bit        pg_known [NPAGES];
    bit [3:0]  pg_ord   [NPAGES];
    int        nxt_pg   [NPAGES];
    int        prv_pg   [NPAGES];
    int        lst_head [TOP_ORD+1];
    int        lst_tail [TOP_ORD+1];

    t_out_word expected_words[$];
    int        held_blocks[$];     // pages currently allocated, for realistic frees
    int        mismatches;
    bit        timed_out;

    function automatic void list_push(int p, int k);
        int t;
        t = lst_tail[k];
        prv_pg[p] = t;
        nxt_pg[p] = NIL;
        if (t == NIL) lst_head[k] = p;
        else nxt_pg[t] = p;
        lst_tail[k] = p;
        pg_ord[p] = k[3:0];
        pg_known[p] = 1'b1;
        pg_taken[p] = 1'b0;
    endfunction

    function automatic void list_drop(int p, int k);
        int a;
        int b;
        a = prv_pg[p];
        b = nxt_pg[p];
        if (a == NIL) lst_head[k] = b;
        else nxt_pg[a] = b;
        if (b == NIL) lst_tail[k] = a;
        else prv_pg[b] = a;
        prv_pg[p] = NIL;
        nxt_pg[p] = NIL;
        pg_taken[p] = 1'b1;
    endfunction

    function automatic void pool_reset();
        int p;
        int k;
        for (p = 0; p < NPAGES; p++) begin
            pg_taken[p] = 0; pg_known[p] = 0; pg_ord[p] = 0;
            nxt_pg[p] = NIL; prv_pg[p] = NIL;
        end
        for (k = 0; k <= TOP_ORD; k++) begin
            lst_head[k] = NIL; lst_tail[k] = NIL;
        end
        p = 0;
        while (p < NPAGES) begin
            k = TOP_ORD;
            while (k > 0 && !((p % (1 << k)) == 0 && (1 << k) <= NPAGES - p)) k--;
            list_push(p, k);
            p += 1 << k;
        end
    endfunction

    function automatic t_out_word alloc_predict(t_in_word w);
        t_out_word r;
        int i;
        int t;
        int c;
        int ord;
        r = '0;
        ord = w.block_order;
        if (ord > TOP_ORD) begin
            r.status = ST_BAD_ORDER;
            return r;
        end
        i = ord;
        while (i <= TOP_ORD && lst_head[i] == NIL) i++;
        if (i > TOP_ORD) begin
            r.status = ST_NO_MEMORY;
            return r;
        end
        t = lst_head[i];
        list_drop(t, i);
        pg_ord[t] = ord[3:0];
        pg_known[t] = 1'b1;
        for (c = i; c > ord; c--)
            if ((t ^ (1 << (c-1))) < NPAGES) list_push(t ^ (1 << (c-1)), c-1);
        r.status = ST_OK;
        r.block_page = t[11:0];
        r.result_order = ord[3:0];
        held_blocks.push_back(t);
        return r;
    endfunction

    function automatic t_out_word free_predict(t_in_word w);
        t_out_word r;
        int p;
        int k;
        int b;
        r = '0;
        p = w.page_index;
        if (p >= NPAGES || !pg_taken[p] || !pg_known[p]) begin
            r.status = ST_IGNORED;
            return r;
        end
        k = pg_ord[p];
        while (k < TOP_ORD) begin
            b = p ^ (1 << k);
            if (b >= NPAGES || pg_taken[b] || !pg_known[b] || pg_ord[b] != k) break;
            list_drop(b, k);
            pg_known[b] = 0;
            pg_known[p] = 0;
            p = p & ~(1 << k);
            k++;
            pg_ord[p] = k[3:0];
            pg_known[p] = 1'b1;
        end
        list_push(p, k);
        r.status = ST_OK;
        r.block_page = p[11:0];
        r.result_order = k[3:0];
        return r;
    endfunction

    // drive one word; predicts it and optionally checks the prediction against a typed value
    task automatic send_word(t_in_word w, bit has_fixed, t_out_word fixed);
        t_out_word e;
        if (w.command == CMD_ALLOC) e = alloc_predict(w);
        else e = free_predict(w);
        if (has_fixed && e !== fixed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("predictor disagrees with table: exp %h got %h", fixed, e);
        end
        expected_words.push_back(e);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic send_gap();
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic t_in_word mk(logic c, int o, int p);
        t_in_word w;
        w.command = c;
        w.block_order = o[3:0];
        w.page_index = p[11:0];
        return w;
    endfunction

    function automatic t_out_word res(logic [1:0] s, int p, int o);
        t_out_word r;
        r.status = s;
        r.block_page = p[11:0];
        r.result_order = o[3:0];
        return r;
    endfunction

    // receiver: stall pattern and scoreboard
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", o_out_word);
                end else begin
                    t_out_word e;
                    e = expected_words.pop_front();
                    if (o_out_word.status !== e.status
                        || o_out_word.block_page !== e.block_page
                        || o_out_word.result_order !== e.result_order) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d pg=%0d ord=%0d got st=%0d pg=%0d ord=%0d",
                                     e.status, e.block_page, e.result_order,
                                     o_out_word.status, o_out_word.block_page,
                                     o_out_word.result_order);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) stall_mode <= ($urandom_range(0, 63) == 0) ? $urandom_range(0, 2)
                                                                      : stall_mode;

    // watchdog: cycles without any handshake
    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX + 2 * NPAGES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        int i;
        int pick;
        int burst;
        t_in_word w;
        t_in_word dir_words[$];
        bit       dir_fixed[$];
        t_out_word dir_res[$];
        mismatches = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        pool_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: alloc extremes, bad order, frees of unallocated pages, merges
        dir_words.push_back(mk(CMD_ALLOC, 0, 0));        dir_fixed.push_back(1);
        dir_res.push_back(res(ST_OK, 0, 0));
        dir_words.push_back(mk(CMD_ALLOC, 15, 4095));    dir_fixed.push_back(1);
        dir_res.push_back(res(ST_BAD_ORDER, 0, 0));
        dir_words.push_back(mk(CMD_ALLOC, 11, 0));       dir_fixed.push_back(1);
        dir_res.push_back(res(ST_BAD_ORDER, 0, 0));
        dir_words.push_back(mk(CMD_FREE, 0, 4095));      dir_fixed.push_back(1);
        dir_res.push_back(res(ST_IGNORED, 0, 0));
        dir_words.push_back(mk(CMD_FREE, 15, 0));        dir_fixed.push_back(1);
        dir_res.push_back(res(ST_OK, 0, 10));
        dir_words.push_back(mk(CMD_FREE, 0, 0));         dir_fixed.push_back(1);
        dir_res.push_back(res(ST_IGNORED, 0, 0));
        dir_words.push_back(mk(CMD_ALLOC, 10, 0));       dir_fixed.push_back(0);
        dir_res.push_back('0);
        dir_words.push_back(mk(CMD_ALLOC, 3, 0));        dir_fixed.push_back(0);
        dir_res.push_back('0);
        dir_words.push_back(mk(CMD_FREE, 0, 1));         dir_fixed.push_back(1);
        dir_res.push_back(res(ST_IGNORED, 0, 0));
        dir_words.push_back(mk(CMD_ALLOC, 5, 0));        dir_fixed.push_back(0);
        dir_res.push_back('0);
        for (i = 0; i < 5; i++) begin
            dir_words.push_back(mk(CMD_ALLOC, 10, 0));   dir_fixed.push_back(0);
            dir_res.push_back('0);
        end
        // pool of 4 order-10 blocks is now exhausted at order 10
        dir_words.push_back(mk(CMD_ALLOC, 10, 0));       dir_fixed.push_back(1);
        dir_res.push_back(res(ST_NO_MEMORY, 0, 0));
        for (i = 0; i < dir_words.size(); i++) begin
            send_word(dir_words[i], dir_fixed[i], dir_res[i]);
            if ($urandom_range(0, 2) == 0) send_gap();
        end
        // free everything held so far, with merging back up
        while (held_blocks.size() > 0) begin
            send_word(mk(CMD_FREE, $urandom_range(0, 15), held_blocks.pop_front()), 0, '0);
        end

        // hold off until drained
        i_in_valid <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);

        n = 0;
        while (n < N_RANDOM) begin
            burst = $urandom_range(1, 20);
            for (i = 0; i < burst && n < N_RANDOM; i++, n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    w = mk(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                   : $urandom_range(0, 4),
                           $urandom_range(0, 4095));
                end else if (pick < 90 && held_blocks.size() > 0) begin
                    int j;
                    j = $urandom_range(0, held_blocks.size() - 1);
                    w = mk(CMD_FREE, $urandom_range(0, 15), held_blocks[j]);
                    held_blocks.delete(j);
                end else begin
                    w = mk(CMD_FREE, $urandom_range(0, 15), $urandom_range(0, 4095));
                    for (int j = 0; j < held_blocks.size(); j++)
                        if (held_blocks[j] == w.page_index && pg_taken[w.page_index]
                            && pg_known[w.page_index]) begin
                            held_blocks.delete(j);
                            break;
                        end
                end
                send_word(w, 0, '0);
            end
            send_gap();
        end

        i_in_valid <= 1'b0;
        while (expected_words.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
